### rtl/core/ssc_pkg.sv
`default_nettype none
package ssc_pkg;

    localparam int TEMP_W = 11;
    localparam int PRES_W = 13;
    localparam int SAT_W = 11;
    localparam int SH_W = 12;
    localparam int DVD_W = 16;
    localparam int REM_W = 13;
    localparam int CNT_W = 4;
    localparam int ROM_LEN = 135;
    localparam int TABLE_ENTRIES_DEF = 135;

    localparam logic [PRES_W-1:0] P_LOW = 13'd53;
    localparam logic [PRES_W-1:0] P_HIGH = 13'd4600;
    localparam logic [SAT_W-1:0] SAT_HIGH = 11'd1090;
    localparam logic [SAT_W-1:0] SAT_MAX = 11'd2047;
    localparam logic [9:0] CLAMP_IDX = 10'd25;
    localparam logic [13:0] SH_OFFSET = 14'd400;

    localparam logic [PRES_W-1:0] PRESS_ROM [ROM_LEN] = '{
        13'd52, 13'd54, 13'd57, 13'd61, 13'd64, 13'd68, 13'd72, 13'd76, 13'd80, 13'd84,
        13'd89, 13'd93, 13'd98, 13'd103, 13'd108, 13'd113, 13'd119, 13'd125, 13'd131,
        13'd138, 13'd144, 13'd151, 13'd157, 13'd165, 13'd172, 13'd181, 13'd188, 13'd196,
        13'd206, 13'd215, 13'd224, 13'd235, 13'd243, 13'd255, 13'd264, 13'd275, 13'd286,
        13'd298, 13'd311, 13'd324, 13'd334, 13'd348, 13'd363, 13'd375, 13'd391, 13'd404,
        13'd424, 13'd435, 13'd453, 13'd468, 13'd483, 13'd504, 13'd520, 13'd538, 13'd556,
        13'd579, 13'd598, 13'd618, 13'd639, 13'd660, 13'd682, 13'd705, 13'd728, 13'd752,
        13'd777, 13'd803, 13'd823, 13'd851, 13'd879, 13'd903, 13'd937, 13'd962, 13'd994,
        13'd1020, 13'd1050, 13'd1090, 13'd1110, 13'd1150, 13'd1180, 13'd1220, 13'd1250,
        13'd1280, 13'd1320, 13'd1350, 13'd1400, 13'd1440, 13'd1470, 13'd1520, 13'd1560,
        13'd1600, 13'd1640, 13'd1680, 13'd1730, 13'd1780, 13'd1820, 13'd1880, 13'd1910,
        13'd1960, 13'd2030, 13'd2080, 13'd2130, 13'd2180, 13'd2240, 13'd2290, 13'd2350,
        13'd2410, 13'd2460, 13'd2510, 13'd2580, 13'd2650, 13'd2710, 13'd2770, 13'd2840,
        13'd2910, 13'd2980, 13'd3050, 13'd3100, 13'd3180, 13'd3250, 13'd3320, 13'd3400,
        13'd3480, 13'd3540, 13'd3630, 13'd3720, 13'd3780, 13'd3900, 13'd3970, 13'd4094,
        13'd4184, 13'd4275, 13'd4369, 13'd4464, 13'd4562, 13'd4600
    };

    // Entries past the end of the stored table repeat the top pressure.
    function automatic logic [PRES_W-1:0] table_entry(input logic [7:0] idx);
        logic [PRES_W-1:0] val;
        if (idx < 8'(ROM_LEN)) begin
            val = PRESS_ROM[idx];
        end else begin
            val = P_HIGH;
        end
        return val;
    endfunction

    typedef struct packed {
        logic load;
        logic step;
        logic load_seg;
        logic div;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic oor;
        logic adjacent;
        logic hit;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

### rtl/core/ssc_ctrl.sv
`default_nettype none
module ssc_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  ssc_pkg::t_stat    i_stat,
    output ssc_pkg::t_cmd     o_cmd
);
    import ssc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_SEG  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                priority if (i_stat.oor) begin
                    n_state = S_FIN;
                end else if (i_stat.adjacent) begin
                    n_state = S_SEG;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_stat.hit) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_SEG: begin
                o_cmd.load_seg = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### rtl/core/ssc_datapath.sv
`default_nettype none
module ssc_datapath #(
    parameter int TABLE_ENTRIES = ssc_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  ssc_pkg::t_cmd                    i_cmd,
    output ssc_pkg::t_stat                   o_stat,
    input  wire logic [ssc_pkg::TEMP_W-1:0]  i_temp,
    input  wire logic [ssc_pkg::PRES_W-1:0]  i_pres,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [ssc_pkg::SAT_W-1:0]        o_sat,
    output logic [ssc_pkg::SH_W-1:0]         o_sh
);
    import ssc_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic [TEMP_W-1:0] r_temp;
    logic [PRES_W-1:0] r_pres;
    logic              r_low;
    logic              r_high;
    logic [IW-1:0]     r_lo;
    logic [IW-1:0]     r_hi;
    logic [PRES_W-1:0] r_den;
    logic [DVD_W-1:0]  r_dvd;
    logic [REM_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [SAT_W-1:0]  r_sat;
    logic [SH_W-1:0]   r_sh;

    logic [IW:0]        mid_sum;
    logic [IW-1:0]      mid;
    logic [PRES_W-1:0]  t_mid;
    logic [PRES_W-1:0]  t_lo;
    logic [PRES_W-1:0]  t_hi;
    logic [PRES_W:0]    den_raw;
    logic               den_pos;
    logic [PRES_W-1:0]  num;
    logic [16:0]        num10;
    logic [REM_W:0]     rem_sh;
    logic               q_bit;
    logic signed [9:0]  k;
    logic signed [17:0] k_ext;
    logic signed [17:0] v;
    logic [SAT_W-1:0]   sat;
    logic [13:0]        sh_raw;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid = mid_sum[IW:1];
    assign t_mid = table_entry(8'(mid));
    assign t_lo = table_entry(8'(r_lo));
    assign t_hi = table_entry(8'(r_hi));

    // A flat segment contributes no fraction.
    assign den_raw = {1'b0, t_hi} - {1'b0, t_lo};
    assign den_pos = !den_raw[PRES_W] && (den_raw != '0);
    assign num = r_pres - t_lo;
    assign num10 = 17'(num) * 17'd10;

    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign q_bit = (rem_sh >= {1'b0, r_den});

    // Whole degrees above the clamp index contribute ten tenths each; the
    // quotient adds the interpolated tenths, so negatives clamp to zero.
    assign k = $signed(10'(r_lo) - CLAMP_IDX);
    assign k_ext = 18'(k);
    assign v = k_ext * 18'sd10 + $signed({2'b00, r_dvd});

    always_comb begin
        priority if (r_low) begin
            sat = '0;
        end else if (r_high) begin
            sat = SAT_HIGH;
        end else if (v[17]) begin
            sat = '0;
        end else if (v > 18'sd2047) begin
            sat = SAT_MAX;
        end else begin
            sat = v[SAT_W-1:0];
        end
    end

    assign sh_raw = 14'(r_temp) + SH_OFFSET - 14'(sat);

    assign o_stat.oor = r_low || r_high;
    assign o_stat.adjacent = ((r_hi - r_lo) == IW'(1));
    assign o_stat.hit = (t_mid == r_pres);
    assign o_stat.div_last = (r_cnt == CNT_W'(DVD_W - 1));
    assign o_stat.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_temp <= i_temp;
            r_pres <= i_pres;
            r_low <= (i_pres < P_LOW);
            r_high <= (i_pres > P_HIGH);
            r_lo <= '0;
            r_hi <= IW'(TABLE_ENTRIES - 1);
        end
        if (i_cmd.step) begin
            if (t_mid == r_pres) begin
                r_lo <= mid;
                r_dvd <= '0;
                r_den <= PRES_W'(1);
                r_rem <= '0;
                r_cnt <= '0;
            end else if (t_mid > r_pres) begin
                r_hi <= mid;
            end else begin
                r_lo <= mid;
            end
        end
        if (i_cmd.load_seg) begin
            r_den <= den_pos ? den_raw[PRES_W-1:0] : PRES_W'(1);
            r_dvd <= den_pos ? num10[DVD_W-1:0] : '0;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div) begin
            r_rem <= q_bit ? REM_W'(rem_sh - {1'b0, r_den}) : rem_sh[REM_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], q_bit};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.fin) begin
            r_sat <= sat;
            r_sh <= sh_raw[13] ? '0 : sh_raw[SH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_sat = r_sat;
    assign o_sh = r_sh;

endmodule
`default_nettype wire

### rtl/core/saturation_superheat_calc_top.sv
// Flow: after an input transfer, an out-of-range pressure goes straight to the output
// state; otherwise the binary search (up to clog2(TABLE_ENTRIES) probes) ends on an
// adjacent pair, loaded as the segment, or on an exact table hit; a restoring divider
// then works through the 16-bit dividend and the result goes to the output register.
// Throughput: one item at a time; the next input is taken in the cycle after the result
// is written. The output register holds a result while stalled.
// Reset (synchronous, active low) returns the controller to idle and empties the output.
`default_nettype none
module saturation_superheat_calc_top #(
    parameter int TABLE_ENTRIES = ssc_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // suction_temp [10:0], pressure [23:11]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata    // sat_temp [10:0], superheat [22:11], zero
);
    import ssc_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [SAT_W-1:0] sat;
    logic [SH_W-1:0]  sh;

    ssc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ssc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_temp  (i_s_axis_tdata[TEMP_W-1:0]),
        .i_pres  (i_s_axis_tdata[TEMP_W+PRES_W-1:TEMP_W]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_sat   (sat),
        .o_sh    (sh)
    );

    assign o_m_axis_tdata = {1'b0, sh, sat};

endmodule
`default_nettype wire

### rtl/core/ssc_checker.sv
`default_nettype none
module ssc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [23:0] i_s_axis_tdata,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata
);

    logic in_xfer;
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // A waiting result must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_s_axis_tready)
        else $error("input taken while an item is in work");

    // A result never appears in the cycle right after its input transfer.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared too early");

    // The superheat is bounded and the padding bit stays zero.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[22:11] <= 12'd2447) && !o_m_axis_tdata[23])
        else $error("result out of range");

endmodule

bind saturation_superheat_calc_top ssc_checker u_ssc_checker (.*);
`default_nettype wire
